@@ rtl/baro_sensor_compensation_defines.svh @@
// Assertion macros for the barometer compensation block.
// Included by the top level; no other dependencies.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define BSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("baro compensation check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define BSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("baro compensation check failed");
`else
`define BSC_ASSERT_IMP(label, ante, cons)
`define BSC_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/bsc_pkg.sv @@
// Package for the barometer compensation block: widths, constants and types.
// No dependencies; used by every module of the block.
package bsc_pkg;

    // Field widths of the ports.
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TOUT_W    = 15;
    localparam int POUT_W    = 17;

    // Number of pipeline register stages.
    localparam int NSTG = 10;

    // Internal datapath widths (signed two's complement).
    localparam int DT_W       = 25;
    localparam int PT_W       = 42;
    localparam int PDD_W      = 50;
    localparam int TEMP_W     = 20;
    localparam int OFF_W      = 40;
    localparam int SENS_W     = 40;
    localparam int SQ_W       = 40;
    localparam int ACC_W      = 44;
    localparam int SENS_SPLIT = 20;
    localparam int PLO_W      = 46;
    localparam int PHI_W      = 45;
    localparam int PROD_W     = 65;
    localparam int Q_W        = 45;
    localparam int P_W        = 30;

    // Scheme constants, temperature in 0.01 C and pressure in 0.01 mbar.
    localparam int TEMP_REF  = 2000;
    localparam int TEMP_DEEP = -1500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MIN  = 1000;
    localparam int PRES_MAX  = 120000;

    // Power-of-two scalings.
    localparam int SH_TEMP = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;

    // Calibration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_SENS     = 3'd0,
        REG_CAL_OFF      = 3'd1,
        REG_CAL_TCS      = 3'd2,
        REG_CAL_TCO      = 3'd3,
        REG_CAL_TREF     = 3'd4,
        REG_CAL_TEMPSENS = 3'd5
    } cfg_reg_t;

    // Calibration words C1..C6.
    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] off;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
    } cal_t;

    typedef logic [NSTG-1:0] stage_en_t;

    // Pipeline control: per-stage load enables and valid bits.
    typedef struct packed {
        stage_en_t en;
        stage_en_t vld;
    } pipe_ctrl_t;

    // Hand-off from the compensation stages to the pressure stages.
    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic [TOUT_W-1:0] temp;
        logic              tclamp;
        logic [OFF_W-1:0]  off_c;
        logic [SENS_W-1:0] sens_c;
    } comp_t;

endpackage

@@ rtl/bsc_cfg.sv @@
// Calibration register file of the barometer compensation block.
// Depends on bsc_pkg.
module bsc_cfg
    import bsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data,
    output cal_t                 cal
);

    cal_t cal_reg;
    cal_t cal_next;

    // The register file always takes a write.
    assign cfg_ready = 1'b1;

    // Decode the index; indexes past the last register are dropped.
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAL_SENS:     cal_next.sens     = cfg_data;
                REG_CAL_OFF:      cal_next.off      = cfg_data;
                REG_CAL_TCS:      cal_next.tcs      = cfg_data;
                REG_CAL_TCO:      cal_next.tco      = cfg_data;
                REG_CAL_TREF:     cal_next.tref     = cfg_data;
                REG_CAL_TEMPSENS: cal_next.tempsens = cfg_data;
                default:          cal_next          = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

@@ rtl/bsc_ctrl.sv @@
// Valid bits and load enables of the ten-stage compensation pipeline.
// Depends on bsc_pkg.
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       out_stall,
    output pipe_ctrl_t pipe
);

    stage_en_t vld_reg;
    stage_en_t vld_next;
    stage_en_t en;

    // A stage loads when it is empty or when the stage after it loads,
    // so bubbles collapse and a held beat is never overwritten.
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall = !en[0];
    assign pipe.en  = en;
    assign pipe.vld = vld_reg;

endmodule

@@ rtl/bsc_comp.sv @@
// Stages one to six: dT, first-order TEMP/OFF/SENS, second-order corrections
// and temperature saturation. Depends on bsc_pkg.
module bsc_comp
    import bsc_pkg::*;
(
    input  logic             clk,
    input  stage_en_t        en,
    input  cal_t             cal,
    input  logic [RAW_W-1:0] raw_pressure,
    input  logic [RAW_W-1:0] raw_temperature,
    output comp_t            comp
);

    // Stage 1 registers.
    logic signed [DT_W-1:0]  s1_dt_reg,   s1_dt_next;
    logic        [RAW_W-1:0] s1_d1_reg;

    // Stage 2 registers.
    logic signed [PT_W-1:0]  s2_pt_reg,   s2_pt_next;
    logic signed [PT_W-1:0]  s2_po_reg,   s2_po_next;
    logic signed [PT_W-1:0]  s2_ps_reg,   s2_ps_next;
    logic signed [PDD_W-1:0] s2_pdd_reg,  s2_pdd_next;
    logic        [RAW_W-1:0] s2_d1_reg;

    // Stage 3 registers.
    logic signed [TEMP_W-1:0] s3_temp_reg, s3_temp_next;
    logic signed [OFF_W-1:0]  s3_off_reg,  s3_off_next;
    logic signed [SENS_W-1:0] s3_sens_reg, s3_sens_next;
    logic signed [TEMP_W-1:0] s3_t2_reg,   s3_t2_next;
    logic        [RAW_W-1:0]  s3_d1_reg;

    // Stage 4 registers.
    logic signed [SQ_W-1:0]   s4_u_reg,    s4_u_next;
    logic signed [SQ_W-1:0]   s4_v_reg,    s4_v_next;
    logic                     s4_low_reg,  s4_low_next;
    logic                     s4_vlow_reg, s4_vlow_next;
    logic signed [TEMP_W-1:0] s4_temp_reg;
    logic signed [TEMP_W-1:0] s4_t2_reg;
    logic signed [OFF_W-1:0]  s4_off_reg;
    logic signed [SENS_W-1:0] s4_sens_reg;
    logic        [RAW_W-1:0]  s4_d1_reg;

    // Stage 5 registers.
    logic signed [OFF_W-1:0]  s5_off2_reg,  s5_off2_next;
    logic signed [SENS_W-1:0] s5_sens2_reg, s5_sens2_next;
    logic signed [TEMP_W-1:0] s5_temp_reg,  s5_temp_next;
    logic signed [OFF_W-1:0]  s5_off_reg;
    logic signed [SENS_W-1:0] s5_sens_reg;
    logic        [RAW_W-1:0]  s5_d1_reg;

    // Stage 6 registers.
    logic signed [OFF_W-1:0]  s6_offc_reg,  s6_offc_next;
    logic signed [SENS_W-1:0] s6_sensc_reg, s6_sensc_next;
    logic        [TOUT_W-1:0] s6_temp_reg,  s6_temp_next;
    logic                     s6_tclamp_reg, s6_tclamp_next;
    logic        [RAW_W-1:0]  s6_d1_reg;

    // Intermediate terms of the second-order stage.
    logic signed [TEMP_W-1:0] s3_xm;
    logic signed [TEMP_W-1:0] s3_xp;
    logic signed [ACC_W-1:0]  s4_u5;
    logic signed [ACC_W-1:0]  s4_v7;
    logic signed [ACC_W-1:0]  s4_v11;
    logic signed [ACC_W-1:0]  s4_off2;
    logic signed [ACC_W-1:0]  s4_sens2;

    // Stage 1: temperature difference dT = D2 - C5 * 2^8.
    assign s1_dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.tref, 8'h00});

    // Stage 2: the four products that depend on dT.
    assign s2_pt_next  = s1_dt_reg * $signed({1'b0, cal.tempsens});
    assign s2_po_next  = s1_dt_reg * $signed({1'b0, cal.tco});
    assign s2_ps_next  = s1_dt_reg * $signed({1'b0, cal.tcs});
    assign s2_pdd_next = s1_dt_reg * s1_dt_reg;

    // Stage 3: first-order temperature, offset and sensitivity, and T2.
    assign s3_temp_next = TEMP_W'(PT_W'(TEMP_REF) + (s2_pt_reg >>> SH_TEMP));
    assign s3_off_next  = OFF_W'(PT_W'($signed({1'b0, cal.off, 16'h0000}))
                                 + (s2_po_reg >>> SH_OFF));
    assign s3_sens_next = SENS_W'(PT_W'($signed({1'b0, cal.sens, 15'h0000}))
                                  + (s2_ps_reg >>> SH_SENS));
    assign s3_t2_next   = TEMP_W'(s2_pdd_reg >>> SH_T2);

    // Stage 4: squared distances below 20 C and below -15 C.
    assign s3_xm        = s3_temp_reg - TEMP_W'(TEMP_REF);
    assign s3_xp        = s3_temp_reg - TEMP_W'(TEMP_DEEP);
    assign s4_u_next    = s3_xm * s3_xm;
    assign s4_v_next    = s3_xp * s3_xp;
    assign s4_low_next  = s3_temp_reg < TEMP_W'(TEMP_REF);
    assign s4_vlow_next = s3_temp_reg < TEMP_W'(TEMP_DEEP);

    // Stage 5: OFF2, SENS2 from shifts and adds, and the corrected TEMP.
    always_comb
    begin
        s4_u5    = (ACC_W'(s4_u_reg) <<< 2) + ACC_W'(s4_u_reg);
        s4_v7    = (ACC_W'(s4_v_reg) <<< 3) - ACC_W'(s4_v_reg);
        s4_v11   = (ACC_W'(s4_v_reg) <<< 3) + (ACC_W'(s4_v_reg) <<< 1) + ACC_W'(s4_v_reg);
        s4_off2  = ACC_W'(0);
        s4_sens2 = ACC_W'(0);
        if (s4_low_reg)
        begin
            s4_off2  = s4_u5 >>> 1;
            s4_sens2 = s4_u5 >>> 2;
            if (s4_vlow_reg)
            begin
                s4_off2  = s4_off2 + s4_v7;
                s4_sens2 = s4_sens2 + (s4_v11 >>> 1);
            end
        end
    end

    assign s5_off2_next  = OFF_W'(s4_off2);
    assign s5_sens2_next = SENS_W'(s4_sens2);
    assign s5_temp_next  = s4_temp_reg - (s4_low_reg ? s4_t2_reg : TEMP_W'(0));

    // Stage 6: corrected OFF and SENS, and temperature saturation.
    assign s6_offc_next  = s5_off_reg - s5_off2_reg;
    assign s6_sensc_next = s5_sens_reg - s5_sens2_reg;

    always_comb
    begin
        s6_temp_next   = s5_temp_reg[TOUT_W-1:0];
        s6_tclamp_next = 1'b0;
        if (s5_temp_reg < TEMP_W'(TEMP_MIN))
        begin
            s6_temp_next   = TOUT_W'(TEMP_MIN);
            s6_tclamp_next = 1'b1;
        end
        else if (s5_temp_reg > TEMP_W'(TEMP_MAX))
        begin
            s6_temp_next   = TOUT_W'(TEMP_MAX);
            s6_tclamp_next = 1'b1;
        end
    end

    // Payload registers; each stage loads on its own enable.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_dt_reg <= s1_dt_next;
            s1_d1_reg <= raw_pressure;
        end
        if (en[1])
        begin
            s2_pt_reg  <= s2_pt_next;
            s2_po_reg  <= s2_po_next;
            s2_ps_reg  <= s2_ps_next;
            s2_pdd_reg <= s2_pdd_next;
            s2_d1_reg  <= s1_d1_reg;
        end
        if (en[2])
        begin
            s3_temp_reg <= s3_temp_next;
            s3_off_reg  <= s3_off_next;
            s3_sens_reg <= s3_sens_next;
            s3_t2_reg   <= s3_t2_next;
            s3_d1_reg   <= s2_d1_reg;
        end
        if (en[3])
        begin
            s4_u_reg    <= s4_u_next;
            s4_v_reg    <= s4_v_next;
            s4_low_reg  <= s4_low_next;
            s4_vlow_reg <= s4_vlow_next;
            s4_temp_reg <= s3_temp_reg;
            s4_t2_reg   <= s3_t2_reg;
            s4_off_reg  <= s3_off_reg;
            s4_sens_reg <= s3_sens_reg;
            s4_d1_reg   <= s3_d1_reg;
        end
        if (en[4])
        begin
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;
            s5_temp_reg  <= s5_temp_next;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_d1_reg    <= s4_d1_reg;
        end
        if (en[5])
        begin
            s6_offc_reg   <= s6_offc_next;
            s6_sensc_reg  <= s6_sensc_next;
            s6_temp_reg   <= s6_temp_next;
            s6_tclamp_reg <= s6_tclamp_next;
            s6_d1_reg     <= s5_d1_reg;
        end
    end

    assign comp.d1     = s6_d1_reg;
    assign comp.temp   = s6_temp_reg;
    assign comp.tclamp = s6_tclamp_reg;
    assign comp.off_c  = s6_offc_reg;
    assign comp.sens_c = s6_sensc_reg;

endmodule

@@ rtl/bsc_press.sv @@
// Stages seven to ten: D1 * SENS as two partial products, pressure formation,
// saturation and the output register. Depends on bsc_pkg.
module bsc_press
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  stage_en_t                en,
    input  comp_t                    comp,
    output logic signed [TOUT_W-1:0] temperature_centi,
    output logic        [POUT_W-1:0] pressure_centi_mbar,
    output logic                     clamped
);

    // Stage 7 registers.
    logic signed [PLO_W-1:0]  s7_plo_reg, s7_plo_next;
    logic signed [PHI_W-1:0]  s7_phi_reg, s7_phi_next;
    logic signed [OFF_W-1:0]  s7_off_reg;
    logic        [TOUT_W-1:0] s7_temp_reg;
    logic                     s7_tclamp_reg;

    // Stage 8 registers.
    logic signed [PROD_W-1:0] s8_prod_reg, s8_prod_next;
    logic signed [OFF_W-1:0]  s8_off_reg;
    logic        [TOUT_W-1:0] s8_temp_reg;
    logic                     s8_tclamp_reg;

    // Stage 9 registers.
    logic signed [P_W-1:0]    s9_p_reg, s9_p_next;
    logic        [TOUT_W-1:0] s9_temp_reg;
    logic                     s9_tclamp_reg;

    // Output registers.
    logic        [TOUT_W-1:0] s10_temp_reg;
    logic        [POUT_W-1:0] s10_pres_reg,  s10_pres_next;
    logic                     s10_clamp_reg, s10_clamp_next;

    logic signed [DT_W-1:0]       d1_s;
    logic signed [SENS_SPLIT:0]   sens_lo;
    logic signed [SENS_W-SENS_SPLIT-1:0] sens_hi;
    logic signed [Q_W-1:0]        s8_q;

    // Stage 7: split SENS into an unsigned low part and a signed high part.
    assign d1_s        = $signed({1'b0, comp.d1});
    assign sens_lo     = $signed({1'b0, comp.sens_c[SENS_SPLIT-1:0]});
    assign sens_hi     = $signed(comp.sens_c[SENS_W-1:SENS_SPLIT]);
    assign s7_plo_next = d1_s * sens_lo;
    assign s7_phi_next = d1_s * sens_hi;

    // Stage 8: recombine the partial products.
    assign s8_prod_next = (PROD_W'(s7_phi_reg) <<< SENS_SPLIT) + PROD_W'(s7_plo_reg);

    // Stage 9: P = (D1 * SENS / 2^21 - OFF) / 2^15, both floors.
    assign s8_q      = Q_W'(s8_prod_reg >>> SH_P1) - Q_W'(s8_off_reg);
    assign s9_p_next = P_W'(s8_q >>> SH_P2);

    // Stage 10: pressure saturation and the combined flag.
    always_comb
    begin
        s10_pres_next  = s9_p_reg[POUT_W-1:0];
        s10_clamp_next = s9_tclamp_reg;
        if (s9_p_reg < P_W'(PRES_MIN))
        begin
            s10_pres_next  = POUT_W'(PRES_MIN);
            s10_clamp_next = 1'b1;
        end
        else if (s9_p_reg > P_W'(PRES_MAX))
        begin
            s10_pres_next  = POUT_W'(PRES_MAX);
            s10_clamp_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_plo_reg    <= s7_plo_next;
            s7_phi_reg    <= s7_phi_next;
            s7_off_reg    <= $signed(comp.off_c);
            s7_temp_reg   <= comp.temp;
            s7_tclamp_reg <= comp.tclamp;
        end
        if (en[7])
        begin
            s8_prod_reg   <= s8_prod_next;
            s8_off_reg    <= s7_off_reg;
            s8_temp_reg   <= s7_temp_reg;
            s8_tclamp_reg <= s7_tclamp_reg;
        end
        if (en[8])
        begin
            s9_p_reg      <= s9_p_next;
            s9_temp_reg   <= s8_temp_reg;
            s9_tclamp_reg <= s8_tclamp_reg;
        end
        if (en[9])
        begin
            s10_temp_reg  <= s9_temp_reg;
            s10_pres_reg  <= s10_pres_next;
            s10_clamp_reg <= s10_clamp_next;
        end
    end

    assign temperature_centi   = $signed(s10_temp_reg);
    assign pressure_centi_mbar = s10_pres_reg;
    assign clamped             = s10_clamp_reg;

endmodule

@@ rtl/baro_sensor_compensation.sv @@
// Barometer sample compensation, second-order low-temperature scheme.
// Ten register stages: out_valid rises once an accepted beat has passed through all
// ten of them; one beat per cycle is sustained while out_stall is low.
// The D1 * SENS product is split over a 25x21 and a 25x20 multiplier.
// Reset clears the valid bits and zeroes all six calibration words.
// Uses bsc_pkg, bsc_cfg, bsc_ctrl, bsc_comp, bsc_press and the defines header.
`include "baro_sensor_compensation_defines.svh"

module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CAL_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [RAW_W-1:0]         raw_temperature,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TOUT_W-1:0] temperature_centi,
    output logic        [POUT_W-1:0] pressure_centi_mbar,
    output logic                     clamped
);

    cal_t       cal;
    pipe_ctrl_t pipe;
    comp_t      comp;

    // Calibration register file.
    bsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // Pipeline valid bits and load enables.
    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .pipe      (pipe)
    );

    // Temperature and second-order compensation stages.
    bsc_comp u_comp (
        .clk             (clk),
        .en              (pipe.en),
        .cal             (cal),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .comp            (comp)
    );

    // Pressure stages and output register.
    bsc_press u_press (
        .clk                 (clk),
        .en                  (pipe.en),
        .comp                (comp),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar),
        .clamped             (clamped)
    );

    assign out_valid = pipe.vld[NSTG-1];

    // The input only stalls when every stage holds a beat and the output is held.
    `BSC_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall && (&pipe.vld))
    // An accepted beat always lands in the first stage.
    `BSC_ASSERT_NXT(a_accept_lands, in_valid && !in_stall, pipe.vld[0])
    // Delivered results are always inside the saturation range.
    `BSC_ASSERT_IMP(a_out_range, out_valid, (temperature_centi >= TOUT_W'(TEMP_MIN)) && (temperature_centi <= TOUT_W'(TEMP_MAX)) && (pressure_centi_mbar >= POUT_W'(PRES_MIN)) && (pressure_centi_mbar <= POUT_W'(PRES_MAX)))

endmodule
